// File: src/kpe_pkg.sv
// ----------------------------------------------------------------------------
// kpe_pkg
// Shared types, codes and helpers of the Kronecker product engine.
// ----------------------------------------------------------------------------
package kpe_pkg;

    // Item function codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SIZE_A = 1'b0;
    localparam logic CFG_SIZE_B = 1'b1;

    // Reset values of the size registers
    localparam logic [5:0] SIZE_A_RST = 6'd32;
    localparam logic [4:0] SIZE_B_RST = 5'd16;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int PROD_W = 64;
    localparam int CIDX_W = 9;

    // One read request travelling with its result tags
    typedef struct packed {
        logic                     valid;
        logic [CIDX_W-1:0]        c_row;
        logic [CIDX_W-1:0]        c_col;
        logic                     last;
        logic signed [VAL_W-1:0]  a_value;
    } t_issue;

    // One finished result beat
    typedef struct packed {
        logic [CIDX_W-1:0]        c_row;
        logic [CIDX_W-1:0]        c_col;
        logic signed [PROD_W-1:0] product;
        logic                     last;
    } t_result;

    // Map a size register onto 1..maxv
    function automatic logic [6:0] clamp_size(input logic [6:0] v, input logic [6:0] maxv);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

endpackage

// File: src/kronecker_product_engine_unit.sv
// ----------------------------------------------------------------------------
// kronecker_product_engine_unit
// Kronecker product C = A (x) B with B held in an on-chip store.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall): a load beat (func 0) writes one
//   B element at row b_row, column b_col; a compute beat (func 1) multiplies
//   a_value by every element of B row b_row and emits size_b result beats in
//   column order, last set on the final one. Beats with indices at or above
//   the configured sizes are dropped without results.
//   Output channel (o_out_valid / i_out_stall): c_row, c_col, Q32.32 product.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 size_a, 1 size_b;
//   write only while the block is idle. Ready is always high.
// Timing:
//   A load never holds the input. A compute beat holds it until its row walk
//   has issued size_b store reads, one per cycle while the output queue has
//   room; the store read port sets this rate. The first result passes the
//   store read, the tag and product registers and the queue, then one per cycle
//   unless stalled; stall fills the 4-entry queue and pauses reads, losing none.
// Reset:
//   Clears all control state and sets size_a to 32, size_b to 16. The B
//   store is not cleared; read only elements that were loaded.
// ----------------------------------------------------------------------------
module kronecker_product_engine_unit #(
    parameter int MAX_A = 32,
    parameter int MAX_B = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic signed [31:0]  i_a_value,
    input  logic [4:0]          i_a_row,
    input  logic [4:0]          i_a_col,
    input  logic [3:0]          i_b_row,
    input  logic [3:0]          i_b_col,
    input  logic signed [31:0]  i_b_value,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [8:0]          o_c_row,
    output logic [8:0]          o_c_col,
    output logic signed [63:0]  o_product,
    output logic                o_last,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [5:0]          i_cfg_data
);

    localparam int DEPTH = MAX_B * MAX_B;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [5:0]                    r_size_a;
    logic [4:0]                    r_size_b;

    logic [6:0]                    na;
    logic [6:0]                    nb_full;
    logic [4:0]                    nb;
    logic                          busy;
    logic                          accept;
    logic                          credit_ok;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [kpe_pkg::VAL_W-1:0]     wdata;
    logic                          re;
    logic [AW-1:0]                 raddr;
    logic [kpe_pkg::VAL_W-1:0]     rdata;
    kpe_pkg::t_issue               issue;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_a <= kpe_pkg::SIZE_A_RST;
            r_size_b <= kpe_pkg::SIZE_B_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kpe_pkg::CFG_SIZE_A: r_size_a <= i_cfg_data;
                kpe_pkg::CFG_SIZE_B: r_size_b <= i_cfg_data[4:0];
            endcase
        end
    end

    // Effective sizes; size_b never exceeds MAX_B after clamping
    assign na      = kpe_pkg::clamp_size({1'b0, r_size_a}, 7'(MAX_A));
    assign nb_full = kpe_pkg::clamp_size({2'b00, r_size_b}, 7'(MAX_B));
    assign nb      = nb_full[4:0];

    // Hold the input while a row walk runs
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !o_in_stall;

    kpe_seq #(
        .MAX_B (MAX_B),
        .AW    (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_func      (i_func),
        .i_a_value   (i_a_value),
        .i_a_row     (i_a_row),
        .i_a_col     (i_a_col),
        .i_b_row     (i_b_row),
        .i_b_col     (i_b_col),
        .i_b_value   (i_b_value),
        .i_na        (na),
        .i_nb        (nb),
        .i_credit_ok (credit_ok),
        .o_busy      (busy),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .o_issue     (issue)
    );

    kpe_bstore #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bstore (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    kpe_prod u_prod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_rdata     (rdata),
        .o_credit_ok (credit_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_c_row     (o_c_row),
        .o_c_col     (o_c_col),
        .o_product   (o_product),
        .o_last      (o_last)
    );

endmodule

// File: src/kpe_bstore.sv
// ----------------------------------------------------------------------------
// kpe_bstore
// Synchronous single-write, single-read memory holding the elements of B.
// ----------------------------------------------------------------------------
module kpe_bstore #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [kpe_pkg::VAL_W-1:0]     i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [kpe_pkg::VAL_W-1:0]     o_rdata
);

    logic [kpe_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [kpe_pkg::VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/kpe_seq.sv
// ----------------------------------------------------------------------------
// kpe_seq
// Item decode and read sequencer: writes loads, walks one B row per compute.
// ----------------------------------------------------------------------------
module kpe_seq #(
    parameter int MAX_B = 16,
    parameter int AW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // accepted input beat
    input  logic                       i_accept,
    input  logic                       i_func,
    input  logic signed [31:0]         i_a_value,
    input  logic [4:0]                 i_a_row,
    input  logic [4:0]                 i_a_col,
    input  logic [3:0]                 i_b_row,
    input  logic [3:0]                 i_b_col,
    input  logic signed [31:0]         i_b_value,
    // effective sizes
    input  logic [6:0]                 i_na,
    input  logic [4:0]                 i_nb,
    // downstream space
    input  logic                       i_credit_ok,
    output logic                       o_busy,
    // memory side
    output logic                       o_we,
    output logic [AW-1:0]              o_waddr,
    output logic [kpe_pkg::VAL_W-1:0]  o_wdata,
    output logic                       o_re,
    output logic [AW-1:0]              o_raddr,
    output kpe_pkg::t_issue            o_issue
);

    logic                      r_busy;
    logic [4:0]                r_k;
    logic [3:0]                r_b_row;
    logic [8:0]                r_c_row;
    logic [8:0]                r_c_col_base;
    logic signed [31:0]        r_a_value;

    logic                      n_busy;
    logic [4:0]                n_k;

    logic                      ld_ok;
    logic                      cmp_ok;
    logic                      issue;
    logic                      k_last;
    logic [15:0]               waddr_full;
    logic [15:0]               raddr_full;
    logic [10:0]               c_row_full;
    logic [9:0]                c_col_base_full;
    logic [8:0]                c_col;

    // Range checks against the effective sizes
    assign ld_ok  = i_accept && (i_func == kpe_pkg::FUNC_LOAD)
                 && ({1'b0, i_b_row} < i_nb) && ({1'b0, i_b_col} < i_nb);
    assign cmp_ok = i_accept && (i_func == kpe_pkg::FUNC_COMPUTE)
                 && ({2'b00, i_a_row} < i_na) && ({2'b00, i_a_col} < i_na)
                 && ({1'b0, i_b_row} < i_nb);

    // Load write goes straight to the store; reads never run in the same cycle
    assign waddr_full = 16'(i_b_row) * 16'(MAX_B) + 16'(i_b_col);
    assign o_we       = ld_ok;
    assign o_waddr    = waddr_full[AW-1:0];
    assign o_wdata    = i_b_value;

    // Result indices of the compute item
    assign c_row_full      = 11'(i_a_row) * 11'(i_nb) + 11'(i_b_row);
    assign c_col_base_full = 10'(i_a_col) * 10'(i_nb);

    // One read per cycle while there is room downstream
    assign issue      = r_busy && i_credit_ok;
    assign k_last     = (r_k == (i_nb - 5'd1));
    assign raddr_full = 16'(r_b_row) * 16'(MAX_B) + 16'(r_k);
    assign c_col      = r_c_col_base + 9'(r_k);

    assign o_re    = issue;
    assign o_raddr = raddr_full[AW-1:0];
    assign o_busy  = r_busy;

    always_comb begin
        o_issue         = '0;
        o_issue.valid   = issue;
        o_issue.c_row   = r_c_row;
        o_issue.c_col   = c_col;
        o_issue.last    = k_last;
        o_issue.a_value = r_a_value;
    end

    // Advance the column counter, drop busy after the last read
    always_comb begin
        n_busy = r_busy;
        n_k    = r_k;
        if (cmp_ok) begin
            n_busy = 1'b1;
            n_k    = '0;
        end else if (issue) begin
            n_k = r_k + 5'd1;
            if (k_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else begin
            r_busy <= n_busy;
            r_k    <= n_k;
        end
    end

    // Hold the item payload for the whole row walk
    always_ff @(posedge i_clk) begin
        if (cmp_ok) begin
            r_b_row      <= i_b_row;
            r_c_row      <= c_row_full[8:0];
            r_c_col_base <= c_col_base_full[8:0];
            r_a_value    <= i_a_value;
        end
    end

endmodule

// File: src/kpe_prod.sv
// ----------------------------------------------------------------------------
// kpe_prod
// Tag alignment, 32x32 signed multiply and output queue with credit.
// ----------------------------------------------------------------------------
module kpe_prod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kpe_pkg::t_issue               i_issue,
    input  logic [kpe_pkg::VAL_W-1:0]     i_rdata,
    output logic                          o_credit_ok,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [8:0]                    o_c_row,
    output logic [8:0]                    o_c_col,
    output logic signed [63:0]            o_product,
    output logic                          o_last
);

    localparam int QD = 4;

    kpe_pkg::t_issue           r_s1;
    logic                      r_s2_valid;
    kpe_pkg::t_result          r_s2;
    kpe_pkg::t_result          r_q [QD];
    logic [1:0]                r_wp;
    logic [1:0]                r_rp;
    logic [2:0]                r_cnt;

    logic signed [63:0]        mul;
    logic                      push;
    logic                      pop;
    logic [2:0]                used;

    // Stage 1: tag lines up with the registered read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_issue.valid;
        end
        r_s1.c_row   <= i_issue.c_row;
        r_s1.c_col   <= i_issue.c_col;
        r_s1.last    <= i_issue.last;
        r_s1.a_value <= i_issue.a_value;
    end

    // Stage 2: register the product
    assign mul = r_s1.a_value * $signed(i_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1.valid;
        end
        r_s2.c_row   <= r_s1.c_row;
        r_s2.c_col   <= r_s1.c_col;
        r_s2.product <= mul;
        r_s2.last    <= r_s1.last;
    end

    // Output queue; reserve a slot for every beat in flight
    assign push        = r_s2_valid;
    assign pop         = (r_cnt != 3'd0) && !i_out_stall;
    assign used        = r_cnt + 3'(r_s1.valid) + 3'(r_s2_valid);
    assign o_credit_ok = (used < 3'(QD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= r_s2;
        end
    end

    // Present the queue head
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_c_row     = r_q[r_rp].c_row;
    assign o_c_col     = r_q[r_rp].c_col;
    assign o_product   = r_q[r_rp].product;
    assign o_last      = r_q[r_rp].last;

endmodule

// File: src/kpe_checker.sv
// ----------------------------------------------------------------------------
// kpe_checker
// Port-level checks of the Kronecker product engine, bound to the top level.
// ----------------------------------------------------------------------------
module kpe_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  logic                i_func,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  logic [8:0]          o_c_row,
    input  logic [8:0]          o_c_col,
    input  logic signed [63:0]  o_product,
    input  logic                o_last
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_c_row) && $stable(o_c_col)
                                     && $stable(o_product) && $stable(o_last))
        else $error("stalled result beat changed");

    // Reset leaves the block empty and open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // A load never starts a row walk
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_func == kpe_pkg::FUNC_LOAD) |=> !o_in_stall)
        else $error("load beat blocked the input");

endmodule

bind kronecker_product_engine_unit kpe_checker u_kpe_checker (.*);
